### design/mbe_pkg.sv
// Shared types and constants of the Mandelbrot escape-time block.
package mbe_pkg;

	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 3;
	localparam int ITER_W    = 10;
	localparam int COLOUR_W  = 16;
	localparam int DP_W      = 64;
	localparam int HALF_W    = DP_W / 2;
	localparam int OUT_TDATA_W = ((ITER_W + COLOUR_W + 7) / 8) * 8;
	localparam int QDEPTH    = 2;

	localparam logic [REG_IDX_W-1:0] REG_START_REAL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_IMAG = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_REAL  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

	localparam logic [CFG_W-1:0]  START_REAL_RST = 32'hFFDE_6667;
	localparam logic [CFG_W-1:0]  START_IMAG_RST = 32'h0018_0000;
	localparam logic [CFG_W-1:0]  STEP_REAL_RST  = 32'h0000_2666;
	localparam logic [CFG_W-1:0]  STEP_IMAG_RST  = 32'h0000_3333;
	localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 10'd128;

	localparam int COL_MUL_HI = 29;
	localparam int COL_MUL_LO = 67;
	localparam int COL_SHIFT  = 8;

	typedef struct packed {
		logic [CFG_W-1:0]  start_real;
		logic [CFG_W-1:0]  start_imag;
		logic [CFG_W-1:0]  step_real;
		logic [CFG_W-1:0]  step_imag;
		logic [ITER_W-1:0] iteration_limit;
	} cfg_regs_t;

	typedef struct packed {
		logic [DP_W-1:0] cre;
		logic [DP_W-1:0] cim;
	} point_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] pixel_colour;
		logic [ITER_W-1:0]   remaining_count;
	} result_t;

endpackage

### design/mandelbrot_escape_time_fixed.sv
// Top level of the fixed-point Mandelbrot escape-time block.
// Each transfer on the input stream carries one pixel (pixel_x, pixel_y); each
// transfer on the output stream carries its remaining iteration count and colour,
// in the order the pixels arrived. The front end forms the point c in a product
// register and a sum register and passes it through a two-entry queue, so it
// keeps taking pixels while the engine works until the queue is full. The engine
// runs each round of the recurrence as partial products, product assembly and
// shift, then escape test and update, on a single set of 32-bit multipliers; the
// number of rounds tried is at most iteration_limit (reset limit 128). A finished
// result waits in an output register while the next pixel is already being
// iterated. The user must write configuration through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce it.
module mandelbrot_escape_time_fixed #(
	parameter int FRAC_BITS  = 20,
	parameter int COORD_BITS = 12,
	localparam int IN_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mbe_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [mbe_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pixel_x, pixel_y, zero padding
	input  logic [IN_TDATA_W-1:0]               s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// remaining_count, pixel_colour, zero padding
	output logic [mbe_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import mbe_pkg::*;

	cfg_regs_t cfg_q;
	point_t    front_pt;
	logic      front_valid;
	logic      queue_ready;
	logic      queue_valid;
	point_t    queue_pt;
	logic      engine_ready;
	result_t   res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_real      <= START_REAL_RST;
			cfg_q.start_imag      <= START_IMAG_RST;
			cfg_q.step_real       <= STEP_REAL_RST;
			cfg_q.step_imag       <= STEP_IMAG_RST;
			cfg_q.iteration_limit <= ITER_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_REAL: cfg_q.start_real      <= cfg_data;
				REG_START_IMAG: cfg_q.start_imag      <= cfg_data;
				REG_STEP_REAL:  cfg_q.step_real       <= cfg_data;
				REG_STEP_IMAG:  cfg_q.step_imag       <= cfg_data;
				REG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mbe_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.pixel_x  (s_tdata[COORD_BITS-1:0]),
		.pixel_y  (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.pt_valid (front_valid),
		.pt_ready (queue_ready),
		.pt       (front_pt)
	);

	mbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (queue_ready),
		.wr_data  (front_pt),
		.rd_valid (queue_valid),
		.rd_ready (engine_ready),
		.rd_data  (queue_pt)
	);

	mbe_engine #(
		.FRAC_BITS (FRAC_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pt_valid  (queue_valid),
		.pt_ready  (engine_ready),
		.pt        (queue_pt),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = OUT_TDATA_W'({res.pixel_colour, res.remaining_count});

endmodule

### design/mbe_front.sv
// Front end: accepts pixel coordinates and forms the complex point c.
module mbe_front #(
	parameter int COORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbe_pkg::cfg_regs_t      cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [COORD_BITS-1:0]   pixel_x,
	input  logic [COORD_BITS-1:0]   pixel_y,
	output logic                    pt_valid,
	input  logic                    pt_ready,
	output mbe_pkg::point_t         pt
);
	import mbe_pkg::*;

	localparam int PROD_W = COORD_BITS + CFG_W + 1;

	logic                     v_s1;
	logic                     v_s2;
	logic                     adv;
	logic signed [PROD_W-1:0] prod_re_s1;
	logic signed [PROD_W-1:0] prod_im_s1;
	point_t                   pt_s2;

	assign adv      = !v_s2 || pt_ready;
	assign in_ready = !v_s1 || adv;
	assign pt_valid = v_s2;
	assign pt       = pt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= v_s1;
			end
			if (in_ready) begin
				v_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			prod_re_s1 <= $signed({1'b0, pixel_x}) * $signed(cfg.step_real);
			prod_im_s1 <= $signed({1'b0, pixel_y}) * $signed(cfg.step_imag);
		end
		if (adv) begin
			pt_s2.cre <= DP_W'($signed(cfg.start_real)) + DP_W'(prod_re_s1);
			pt_s2.cim <= DP_W'($signed(cfg.start_imag)) - DP_W'(prod_im_s1);
		end
	end

endmodule

### design/mbe_queue.sv
// Two-entry queue that carries points from the front end to the engine.
module mbe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  mbe_pkg::point_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output mbe_pkg::point_t rd_data
);
	import mbe_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	point_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign wr_ready = (count_q != CNT_W'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### design/mbe_engine.sv
// Back end: iterates the escape-time recurrence and holds the result.
module mbe_engine #(
	parameter int FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mbe_pkg::cfg_regs_t cfg,
	input  logic               pt_valid,
	output logic               pt_ready,
	input  mbe_pkg::point_t    pt,
	output logic               res_valid,
	input  logic               res_ready,
	output mbe_pkg::result_t   res
);
	import mbe_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [DP_W-1:0] FOUR = DP_W'(4) << FRAC_BITS;
	localparam int HI_W = ITER_W + 5;
	localparam int LO_W = ITER_W + 7;

	logic [2:0]        state_q;
	logic [ITER_W-1:0] n_q;
	logic [DP_W-1:0]   a_q, b_q, cre_q, cim_q;
	logic [DP_W-1:0]   ll_aa_q, ll_bb_q, ll_ab_q;
	logic [HALF_W-1:0] x_aa_q, x_bb_q, x_ab_q;
	logic [DP_W-1:0]   a2_q, b2_q, ab_q;
	logic [DP_W-1:0]   mul_aa, mul_bb, mul_ab;
	logic [DP_W-1:0]   p_aa, p_bb, p_ab;
	logic [DP_W-1:0]   mag;
	logic              escape;
	logic              out_valid_q;
	result_t           res_q;
	logic              load_out;
	logic [HI_W-1:0]   col_hi;
	logic [LO_W-1:0]   col_lo;

	assign pt_ready  = (state_q == S_IDLE);
	assign res_valid = out_valid_q;
	assign res       = res_q;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || res_ready);

	// Low 64 bits of each square and cross product from 32-bit partial products.
	assign mul_aa = a_q[HALF_W-1:0] * a_q[HALF_W-1:0];
	assign mul_bb = b_q[HALF_W-1:0] * b_q[HALF_W-1:0];
	assign mul_ab = a_q[HALF_W-1:0] * b_q[HALF_W-1:0];

	assign p_aa = ll_aa_q + {x_aa_q[HALF_W-2:0], 1'b0, {HALF_W{1'b0}}};
	assign p_bb = ll_bb_q + {x_bb_q[HALF_W-2:0], 1'b0, {HALF_W{1'b0}}};
	assign p_ab = ll_ab_q + {x_ab_q, {HALF_W{1'b0}}};

	assign mag    = a2_q + b2_q;
	assign escape = $signed(mag) >= $signed(FOUR);

	assign col_hi = HI_W'(n_q) * HI_W'(COL_MUL_HI);
	assign col_lo = LO_W'(n_q) * LO_W'(COL_MUL_LO);

	always_ff @(posedge clk) begin
		ll_aa_q <= mul_aa;
		ll_bb_q <= mul_bb;
		ll_ab_q <= mul_ab;
		x_aa_q  <= HALF_W'(a_q[DP_W-1:HALF_W] * a_q[HALF_W-1:0]);
		x_bb_q  <= HALF_W'(b_q[DP_W-1:HALF_W] * b_q[HALF_W-1:0]);
		x_ab_q  <= HALF_W'(a_q[DP_W-1:HALF_W] * b_q[HALF_W-1:0]
			+ a_q[HALF_W-1:0] * b_q[DP_W-1:HALF_W]);
		a2_q    <= DP_W'($signed(p_aa) >>> FRAC_BITS);
		b2_q    <= DP_W'($signed(p_bb) >>> FRAC_BITS);
		ab_q    <= DP_W'($signed(p_ab) >>> (FRAC_BITS - 1));
		if (state_q == S_IDLE && pt_valid) begin
			cre_q <= pt.cre;
			cim_q <= pt.cim;
			a_q   <= pt.cre;
			b_q   <= pt.cim;
		end else if (state_q == S_UPD && !escape) begin
			a_q <= cre_q + a2_q - b2_q;
			b_q <= cim_q + ab_q;
		end
		if (load_out) begin
			res_q.remaining_count <= n_q;
			res_q.pixel_colour    <= {col_hi[COLOUR_W-COL_SHIFT-1:0], {COL_SHIFT{1'b0}}}
				| col_lo[COLOUR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pt_valid) begin
						n_q     <= cfg.iteration_limit;
						state_q <= (cfg.iteration_limit != '0) ? S_MUL : S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (escape) begin
						state_q <= S_DONE;
					end else begin
						n_q     <= n_q - 1'b1;
						state_q <= (n_q == ITER_W'(1)) ? S_DONE : S_MUL;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> n_q <= cfg.iteration_limit)
		else $error("Iteration count exceeds the configured limit.");

	a_round_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && !escape && n_q != ITER_W'(1)) |=> state_q == S_MUL)
		else $error("Engine left the iteration loop early.");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !res_ready) |=> state_q == S_DONE)
		else $error("Result overwritten before its transfer.");
`endif

endmodule
